// ----- sv/tgarle_pkg.sv -----
// Package for the TGA run-length pixel decoder.
// Shared types, codes, queue entry layout and size clamps. No dependencies.
package tgarle_pkg;

   localparam int unsigned MAX_DIM      = 4096;
   localparam int unsigned DIM_W        = 13;
   localparam int unsigned POS_W        = 12;
   localparam int unsigned QUEUE_DEPTH  = 4;
   localparam int unsigned QUEUE_IDX_W  = $clog2(QUEUE_DEPTH);
   localparam int unsigned CSR_IDX_W    = 3;
   localparam int unsigned CSR_DATA_W   = 13;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PIXEL_FORMAT  = 3'd0,
      CSR_RLE_ENABLE    = 3'd1,
      CSR_BOTTOM_TO_TOP = 3'd2,
      CSR_IMAGE_WIDTH   = 3'd3,
      CSR_IMAGE_HEIGHT  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      FMT_GRAY = 2'd0,
      FMT_BGR  = 2'd1,
      FMT_BGRA = 2'd2
   } pixel_format_type;

   typedef enum logic {
      PHASE_HEADER = 1'b0,
      PHASE_PIXEL  = 1'b1
   } phase_type;

   // width and height already clamped to their legal ranges
   typedef struct packed {
      logic [1:0]       pixel_format;
      logic             rle_enable;
      logic             bottom_to_top;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } cfg_type;

   typedef struct packed {
      logic        restart;
      logic        has_run;
      logic [31:0] pixel;
      logic [7:0]  count;
   } run_cmd_type;

   localparam logic [7:0] RUN_HEADER_BASE = 8'd127;

   function automatic logic [DIM_W-1:0] clamp_width(input logic [DIM_W-1:0] w);
      logic [DIM_W-1:0] r;
      r = w;
      if (w > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
      if (w < DIM_W'(4)) r = DIM_W'(4);
      return r;
   endfunction

   function automatic logic [DIM_W-1:0] clamp_height(input logic [DIM_W-1:0] h);
      logic [DIM_W-1:0] r;
      r = h;
      if (h > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
      if (h < DIM_W'(1)) r = DIM_W'(1);
      return r;
   endfunction

endpackage

// ----- sv/tgarle_if.sv -----
// Channel interfaces of the TGA run-length pixel decoder.
// Request bytes, span responses and register writes. No dependencies.
interface tgarle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       image_start;
   modport source (output valid, data_byte, image_start, input ready);
   modport sink   (input valid, data_byte, image_start, output ready);
endinterface

interface tgarle_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_value;
   logic [11:0] dest_row;
   logic [11:0] start_column;
   logic [7:0]  span_length;
   logic        last_span;
   logic        image_done;
   modport source (output valid, pixel_value, dest_row, start_column, span_length,
                   last_span, image_done, input ready);
   modport sink   (input valid, pixel_value, dest_row, start_column, span_length,
                   last_span, image_done, output ready);
endinterface

interface tgarle_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [12:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/tgarle_front.sv -----
// Front end: packet header parsing and pixel byte gathering.
// Pushes run commands into the queue. Uses tgarle_pkg and tgarle_req_if.
module tgarle_front
   import tgarle_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   tgarle_req_if.sink    req,
   input  cfg_type       cfg,
   input  logic          queue_full,
   output logic          push,
   output run_cmd_type   push_cmd
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  rem_ff, rem_in;
   logic        isrun_ff, isrun_in;
   logic [1:0]  idx_ff, idx_in;
   logic [23:0] gather_ff, gather_in;

   phase_type   phase_s;
   logic [7:0]  rem_s;
   logic        isrun_s;
   logic [1:0]  idx_s;
   logic [23:0] gather_s;
   logic [1:0]  last_idx;
   logic        take, hdr, gathering, done;
   logic [7:0]  b;

   assign req.ready = !queue_full;
   assign take      = req.valid && req.ready;
   assign b         = req.data_byte;

   assign phase_s  = req.image_start ? PHASE_HEADER : phase_ff;
   assign rem_s    = req.image_start ? 8'd0 : rem_ff;
   assign isrun_s  = req.image_start ? 1'b0 : isrun_ff;
   assign idx_s    = req.image_start ? 2'd0 : idx_ff;
   assign gather_s = req.image_start ? 24'd0 : gather_ff;

   assign last_idx  = (cfg.pixel_format == FMT_GRAY) ? 2'd0 :
                      (cfg.pixel_format == FMT_BGR)  ? 2'd2 : 2'd3;
   assign hdr       = cfg.rle_enable && (phase_s == PHASE_HEADER);
   assign gathering = !hdr && (idx_s < last_idx);
   assign done      = !hdr && !gathering;

   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         phase_in = phase_s;
         if (hdr) begin
            phase_in = PHASE_PIXEL;
         end else if (done) begin
            if (!cfg.rle_enable || isrun_s || rem_s == 8'd1) begin
               phase_in = PHASE_HEADER;
            end
         end
      end
   end

   always_comb begin
      rem_in    = rem_ff;
      isrun_in  = isrun_ff;
      idx_in    = idx_ff;
      gather_in = gather_ff;
      push      = 1'b0;
      push_cmd  = '0;
      push_cmd.restart = req.image_start;
      case (last_idx)
         2'd0:    push_cmd.pixel = {24'd0, b};
         2'd2:    push_cmd.pixel = {8'd0, gather_s[7:0], gather_s[15:8], b};
         default: push_cmd.pixel = {b, gather_s[7:0], gather_s[15:8], gather_s[23:16]};
      endcase
      push_cmd.count = 8'd1;
      if (take) begin
         rem_in    = rem_s;
         isrun_in  = isrun_s;
         idx_in    = idx_s;
         gather_in = gather_s;
         push      = req.image_start;
         if (hdr) begin
            idx_in = 2'd0;
            if (b > RUN_HEADER_BASE) begin
               isrun_in = 1'b1;
               rem_in   = b - RUN_HEADER_BASE;
            end else begin
               isrun_in = 1'b0;
               rem_in   = b + 8'd1;
            end
         end else if (gathering) begin
            case (idx_s)
               2'd0:    gather_in[7:0]   = b;
               2'd1:    gather_in[15:8]  = b;
               default: gather_in[23:16] = b;
            endcase
            idx_in = idx_s + 2'd1;
         end else begin
            idx_in           = 2'd0;
            push             = 1'b1;
            push_cmd.has_run = 1'b1;
            if (!cfg.rle_enable) begin
               rem_in   = 8'd0;
               isrun_in = 1'b0;
            end else if (isrun_s) begin
               push_cmd.count = rem_s;
               rem_in         = 8'd0;
               isrun_in       = 1'b0;
            end else begin
               rem_in = rem_s - 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_HEADER;
         rem_ff    <= 8'd0;
         isrun_ff  <= 1'b0;
         idx_ff    <= 2'd0;
         gather_ff <= 24'd0;
      end else begin
         phase_ff  <= phase_in;
         rem_ff    <= rem_in;
         isrun_ff  <= isrun_in;
         idx_ff    <= idx_in;
         gather_ff <= gather_in;
      end
   end

endmodule

// ----- sv/tgarle_queue.sv -----
// Short run-command queue between front and back ends.
// Uses tgarle_pkg for the entry type and depth.
module tgarle_queue
   import tgarle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  run_cmd_type push_cmd,
   input  logic        pop,
   output logic        full,
   output logic        head_valid,
   output run_cmd_type head_cmd
);

   run_cmd_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_IDX_W:0]       count_ff, count_in;
   logic                       do_push, do_pop;

   assign full       = count_ff == (QUEUE_IDX_W+1)'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = slot_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in    = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (QUEUE_IDX_W+1)'(do_push) - (QUEUE_IDX_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

// ----- sv/tgarle_back.sv -----
// Back end: splits runs into row spans, tracks position, drives responses.
// Uses tgarle_pkg and tgarle_rsp_if.
module tgarle_back
   import tgarle_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          head_valid,
   input  run_cmd_type   head_cmd,
   output logic          pop,
   tgarle_rsp_if.source  rsp
);

   logic [POS_W-1:0] col_ff, col_in, row_ff, row_in;
   logic             fin_ff, fin_in;
   logic             busy_ff, busy_in;
   logic [7:0]       nrem_ff, nrem_in;

   logic             valid_ff, valid_in;
   logic [31:0]      pixel_ff, pixel_in;
   logic [11:0]      drow_ff, drow_in, scol_ff, scol_in;
   logic [7:0]       len_ff, len_in;
   logic             last_ff, last_in, done_ff, done_in;

   logic             restart, step, dead, wrap, at_end, fin_nx, last;
   logic [7:0]       n_cur, n_nx, len;
   logic [POS_W-1:0] col_s, row_s;
   logic             fin_s;
   logic [DIM_W-1:0] col_e, row_e, room, col_nx, row_nx;

   assign restart = !busy_ff && head_cmd.restart;
   assign col_s   = restart ? '0 : col_ff;
   assign row_s   = restart ? '0 : row_ff;
   assign fin_s   = restart ? 1'b0 : fin_ff;
   assign n_cur   = busy_ff ? nrem_ff : head_cmd.count;

   assign wrap   = {1'b0, col_s} >= cfg.width;
   assign col_e  = wrap ? '0 : {1'b0, col_s};
   assign row_e  = {1'b0, row_s} + DIM_W'(wrap);
   assign dead   = !head_cmd.has_run || fin_s || n_cur == 8'd0 ||
                   {1'b0, row_s} >= cfg.height || row_e >= cfg.height;
   assign room   = cfg.width - col_e;
   assign len    = (room > DIM_W'(n_cur)) ? n_cur : room[7:0];
   assign col_nx = col_e + DIM_W'(len);
   assign at_end = col_nx == cfg.width;
   assign row_nx = row_e + DIM_W'(at_end);
   assign fin_nx = at_end && row_nx >= cfg.height;
   assign n_nx   = n_cur - len;
   assign last   = n_nx == 8'd0 || fin_nx;

   assign step = head_valid && (!valid_ff || rsp.ready);
   assign pop  = step && (dead || last);

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      fin_in  = fin_ff;
      busy_in = busy_ff;
      nrem_in = nrem_ff;
      if (step) begin
         if (dead) begin
            col_in  = col_s;
            row_in  = row_s;
            fin_in  = fin_s || (head_cmd.has_run && n_cur != 8'd0);
            busy_in = 1'b0;
         end else begin
            col_in  = at_end ? '0 : col_nx[POS_W-1:0];
            row_in  = row_nx[POS_W-1:0];
            fin_in  = fin_nx;
            busy_in = !last;
            nrem_in = n_nx;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff && !rsp.ready;
      pixel_in = pixel_ff;
      drow_in  = drow_ff;
      scol_in  = scol_ff;
      len_in   = len_ff;
      last_in  = last_ff;
      done_in  = done_ff;
      if (step && !dead) begin
         valid_in = 1'b1;
         pixel_in = head_cmd.pixel;
         drow_in  = cfg.bottom_to_top ? 12'(cfg.height - DIM_W'(1) - row_e) : row_e[11:0];
         scol_in  = col_e[11:0];
         len_in   = len;
         last_in  = last;
         done_in  = fin_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         fin_ff   <= 1'b0;
         busy_ff  <= 1'b0;
         nrem_ff  <= 8'd0;
         valid_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         fin_ff   <= fin_in;
         busy_ff  <= busy_in;
         nrem_ff  <= nrem_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
      drow_ff  <= drow_in;
      scol_ff  <= scol_in;
      len_ff   <= len_in;
      last_ff  <= last_in;
      done_ff  <= done_in;
   end

   assign rsp.valid        = valid_ff;
   assign rsp.pixel_value  = pixel_ff;
   assign rsp.dest_row     = drow_ff;
   assign rsp.start_column = scol_ff;
   assign rsp.span_length  = len_ff;
   assign rsp.last_span    = last_ff;
   assign rsp.image_done   = done_ff;

endmodule

// ----- sv/tga_rle_pixel_decoder_top.sv -----
// Top level of the TGA run-length pixel decoder: registers, front, queue, back.
// Uses tgarle_pkg, tgarle_if, tgarle_front, tgarle_queue and tgarle_back.
//
//   channel   dir   payload                                           request
//   req_bus   in    data_byte[7:0], image_start                       one stream byte
//   rsp_bus   out   pixel_value[31:0], dest_row[11:0], start_column   one row span
//                   [11:0], span_length[7:0], last_span, image_done
//   csr_bus   in    index[2:0], data[12:0]                            register write
//
// Bytes are taken one per cycle while the four-entry run queue has room.
// The back end emits one span per cycle unless the response stalls; a run is
// split into one span per row, and an entry that yields no span is just popped.
// Reset is synchronous; config returns to 24-bit, RLE, top-to-bottom, 4x1.
// A stalled response holds the back end; the front keeps filling the queue.
module tga_rle_pixel_decoder_top
   import tgarle_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   tgarle_req_if.sink    req_bus,
   tgarle_rsp_if.source  rsp_bus,
   tgarle_csr_if.sink    csr_bus
);

   logic [1:0]       fmt_ff;
   logic             rle_ff, btt_ff;
   logic [DIM_W-1:0] width_ff, height_ff;
   cfg_type          cfg;

   logic             queue_full, push, pop, head_valid;
   run_cmd_type      push_cmd, head_cmd;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= FMT_BGR;
         rle_ff    <= 1'b1;
         btt_ff    <= 1'b0;
         width_ff  <= DIM_W'(4);
         height_ff <= DIM_W'(1);
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_PIXEL_FORMAT:  fmt_ff    <= csr_bus.data[1:0];
            CSR_RLE_ENABLE:    rle_ff    <= csr_bus.data[0];
            CSR_BOTTOM_TO_TOP: btt_ff    <= csr_bus.data[0];
            CSR_IMAGE_WIDTH:   width_ff  <= csr_bus.data;
            CSR_IMAGE_HEIGHT:  height_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   assign cfg.pixel_format  = fmt_ff;
   assign cfg.rle_enable    = rle_ff;
   assign cfg.bottom_to_top = btt_ff;
   assign cfg.width         = clamp_width(width_ff);
   assign cfg.height        = clamp_height(height_ff);

   tgarle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .cfg        (cfg),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   tgarle_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   tgarle_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp        (rsp_bus)
   );

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.image_done |-> rsp_bus.last_span)
      else $error("image_done span not marked last");

   a_span_in_row: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> ({1'b0, rsp_bus.start_column} + DIM_W'(rsp_bus.span_length)
                         <= cfg.width) && rsp_bus.span_length != 8'd0)
      else $error("span runs past the row end");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid && !head_valid)
      else $error("response or queue live after reset");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !push)
      else $error("push into a full queue");

endmodule
